/* hdl/ppe_pkg.sv */
// Shared types, constants and the microprogram of the predator-prey Euler stepper.
// Holds the control word layout, the saturation helper and the reset values.
// No dependencies.
package ppe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int TIME_W    = 31;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int CFG_IDX_W = 3;
  localparam int UPC_W     = 5;
  localparam int PROG_LEN  = 19;

  localparam logic [UPC_W-1:0] LOAD_ADDR = UPC_W'(18);

  // Reset values of the coefficients and of the state.
  localparam logic signed [DATA_W-1:0] RST_PREY_GROWTH    = DATA_W'(10 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] RST_PREDATION_RATE = DATA_W'(3 << (FRAC_BITS - 2));
  localparam logic signed [DATA_W-1:0] RST_PREDATOR_DEATH = DATA_W'(1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] RST_PREDATOR_GAIN  =
    DATA_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [TIME_W-1:0]        RST_STEP_SIZE      =
    TIME_W'(((1 << FRAC_BITS) + 100) / 200);
  localparam logic signed [DATA_W-1:0] RST_PREY           = DATA_W'(100 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] RST_PREDATOR       = DATA_W'(5 << FRAC_BITS);

  // Saturation bounds on the wide intermediate format.
  localparam logic signed [PROD_W:0] WIDE_MAX =
    {{(PROD_W - DATA_W + 1){1'b0}}, 1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [PROD_W:0] WIDE_MIN =
    {{(PROD_W - DATA_W + 2){1'b1}}, {(DATA_W - 1){1'b0}}};
  localparam logic signed [PROD_W:0] RND_HALF =
    (PROD_W + 1)'(1) <<< (FRAC_BITS - 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREY_GROWTH    = 3'd0,
    CFG_PREDATION_RATE = 3'd1,
    CFG_PREDATOR_DEATH = 3'd2,
    CFG_PREDATOR_GAIN  = 3'd3,
    CFG_STEP_SIZE      = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef enum logic [2:0] {
    OPA_A = 3'd0,
    OPA_B = 3'd1,
    OPA_C = 3'd2,
    OPA_D = 3'd3,
    OPA_H = 3'd4,
    OPA_X = 3'd5
  } opa_sel_t;

  typedef enum logic [1:0] {
    OPB_X  = 2'd0,
    OPB_Y  = 2'd1,
    OPB_T1 = 2'd2,
    OPB_T2 = 2'd3
  } opb_sel_t;

  typedef enum logic {
    WB_T1 = 1'b0,
    WB_T2 = 1'b1
  } wb_dst_t;

  typedef enum logic [1:0] {
    ALU_T1 = 2'd0,
    ALU_X  = 2'd1,
    ALU_Y  = 2'd2
  } alu_reg_t;

  typedef enum logic [1:0] {
    SEQ_NEXT    = 2'd0,
    SEQ_BR_LOAD = 2'd1,
    SEQ_END     = 2'd2
  } seq_t;

  typedef struct packed {
    logic     mul_en;
    opa_sel_t opa;
    opb_sel_t opb;
    logic     wb_en;
    wb_dst_t  wb_dst;
    logic     alu_en;
    logic     alu_sub;
    alu_reg_t alu_reg;
    logic     load_en;
    logic     fin;
    logic     sat_clr;
    seq_t     seq;
  } ucode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clipped;
  } sat_res_t;

  // Clips a wide signed value to 32-bit signed and reports whether it clipped.
  function automatic sat_res_t sat_clip(input logic signed [PROD_W:0] v);
    sat_res_t r;
    begin
      r.clipped = 1'b1;
      if (v > WIDE_MAX) begin
        r.value = WIDE_MAX[DATA_W-1:0];
      end else if (v < WIDE_MIN) begin
        r.value = WIDE_MIN[DATA_W-1:0];
      end else begin
        r.value   = v[DATA_W-1:0];
        r.clipped = 1'b0;
      end
      return r;
    end
  endfunction

  // The microprogram. T1 and T2 are scratch registers; every multiply result
  // passes through the product register before it is written back.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    begin
      w     = '0;
      w.seq = SEQ_NEXT;
      case (addr)
        5'd0: begin  // a*x; also the dispatch point for load items
          w.mul_en = 1'b1; w.opa = OPA_A; w.opb = OPB_X;
          w.sat_clr = 1'b1; w.seq = SEQ_BR_LOAD;
        end
        5'd1: begin
          w.mul_en = 1'b1; w.opa = OPA_X; w.opb = OPB_Y;
          w.wb_en = 1'b1; w.wb_dst = WB_T1;
        end
        5'd2: begin
          w.wb_en = 1'b1; w.wb_dst = WB_T2;
        end
        5'd3: begin
          w.mul_en = 1'b1; w.opa = OPA_B; w.opb = OPB_T2;
        end
        5'd4: begin
          w.wb_en = 1'b1; w.wb_dst = WB_T2;
        end
        5'd5: begin  // dx
          w.alu_en = 1'b1; w.alu_sub = 1'b1; w.alu_reg = ALU_T1;
        end
        5'd6: begin
          w.mul_en = 1'b1; w.opa = OPA_H; w.opb = OPB_T1;
        end
        5'd7: begin
          w.wb_en = 1'b1; w.wb_dst = WB_T2;
        end
        5'd8: begin  // new prey
          w.alu_en = 1'b1; w.alu_reg = ALU_X;
        end
        5'd9: begin
          w.mul_en = 1'b1; w.opa = OPA_X; w.opb = OPB_Y;
        end
        5'd10: begin
          w.wb_en = 1'b1; w.wb_dst = WB_T1;
        end
        5'd11: begin
          w.mul_en = 1'b1; w.opa = OPA_D; w.opb = OPB_T1;
        end
        5'd12: begin
          w.mul_en = 1'b1; w.opa = OPA_C; w.opb = OPB_Y;
          w.wb_en = 1'b1; w.wb_dst = WB_T1;
        end
        5'd13: begin
          w.wb_en = 1'b1; w.wb_dst = WB_T2;
        end
        5'd14: begin  // dy
          w.alu_en = 1'b1; w.alu_sub = 1'b1; w.alu_reg = ALU_T1;
        end
        5'd15: begin
          w.mul_en = 1'b1; w.opa = OPA_H; w.opb = OPB_T1;
        end
        5'd16: begin
          w.wb_en = 1'b1; w.wb_dst = WB_T2;
        end
        5'd17: begin  // new predator, time, result
          w.alu_en = 1'b1; w.alu_reg = ALU_Y;
          w.fin = 1'b1; w.seq = SEQ_END;
        end
        5'd18: begin
          w.load_en = 1'b1; w.seq = SEQ_END;
        end
        default: begin
          w.seq = SEQ_END;
        end
      endcase
      return w;
    end
  endfunction

endpackage

/* hdl/ppe_mul.sv */
// Shared fixed-point multiplier: registered 32x32 product, then rounding,
// scaling and saturation of the stored product. Depends on ppe_pkg.
module ppe_mul import ppe_pkg::*; (
  input  logic                     clk,
  input  logic                     mul_en,
  input  logic signed [DATA_W-1:0] op_a,
  input  logic signed [DATA_W-1:0] op_b,
  output sat_res_t                 res
);

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W:0]   rnd;
  logic signed [PROD_W:0]   scaled;

  always_comb begin
    prod_nxt = prod_r;
    if (mul_en) begin
      prod_nxt = op_a * op_b;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Round to nearest with ties toward plus infinity, then floor-shift.
  assign rnd    = {prod_r[PROD_W-1], prod_r} + RND_HALF;
  assign scaled = rnd >>> FRAC_BITS;
  assign res    = sat_clip(scaled);

endmodule

/* hdl/predator_prey_euler_step.sv */
// Lotka-Volterra forward Euler stepper in signed fixed point, microcoded.
// Step item: the 18-step microprogram runs through the one shared multiplier;
// a new item is taken only once the block is idle again. Load item: no result.
// A finished result waits in the output register.
// Reset (rst_n low, synchronous) restores the coefficients, prey = 100.0,
// predator = 5.0, time = 0, and empties the output register.
module predator_prey_euler_step import ppe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input item channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic signed [DATA_W-1:0] in_start_prey,
  input  logic signed [DATA_W-1:0] in_start_predator,
  // Result item channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [TIME_W-1:0] out_time_now,
  output logic signed [DATA_W-1:0] out_prey_now,
  output logic signed [DATA_W-1:0] out_predator_now,
  output logic                     out_saturated,
  // Configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic     [CFG_IDX_W-1:0] cfg_index,
  input  logic        [DATA_W-1:0] cfg_data
);

  // Coefficient registers.
  logic signed [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic        [TIME_W-1:0] h_r, h_nxt;

  // Sequencer state.
  state_t           state_r, state_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ucode_t           cw;

  // Captured input item.
  logic                     cmd_r, cmd_nxt;
  logic signed [DATA_W-1:0] ld_prey_r, ld_prey_nxt, ld_pred_r, ld_pred_nxt;

  // Integrator state and scratch registers.
  logic signed [DATA_W-1:0] x_r, x_nxt, y_r, y_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic        [TIME_W-1:0] time_r, time_nxt;
  logic                     sat_r, sat_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic        [TIME_W-1:0] out_time_r, out_time_nxt;
  logic signed [DATA_W-1:0] out_prey_r, out_prey_nxt, out_pred_r, out_pred_nxt;
  logic                     out_sat_r, out_sat_nxt;

  // Datapath signals.
  logic                     run, stall, go, in_acc;
  logic signed [DATA_W-1:0] op_a, op_b, alu_lhs;
  logic signed [DATA_W:0]   alu_sum;
  sat_res_t                 mres, ares;
  logic        [TIME_W:0]   tsum;
  logic        [TIME_W-1:0] tnext;
  logic                     tclip;

  assign cw     = ucode_rom(upc_r);
  assign run    = (state_r == ST_RUN);
  // The last step holds while the previous result has not been taken.
  assign stall  = run && cw.fin && out_valid_r && !out_ready;
  assign go     = run && !stall;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Multiplier operand selection.
  always_comb begin
    case (cw.opa)
      OPA_A:   op_a = a_r;
      OPA_B:   op_a = b_r;
      OPA_C:   op_a = c_r;
      OPA_D:   op_a = d_r;
      OPA_H:   op_a = $signed({1'b0, h_r});
      OPA_X:   op_a = x_r;
      default: op_a = x_r;
    endcase
    case (cw.opb)
      OPB_X:   op_b = x_r;
      OPB_Y:   op_b = y_r;
      OPB_T1:  op_b = t1_r;
      OPB_T2:  op_b = t2_r;
      default: op_b = x_r;
    endcase
  end

  ppe_mul u_mul (
    .clk    (clk),
    .mul_en (go && cw.mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .res    (mres)
  );

  // The adder always takes T2 as its right operand and writes back in place.
  always_comb begin
    case (cw.alu_reg)
      ALU_T1:  alu_lhs = t1_r;
      ALU_X:   alu_lhs = x_r;
      ALU_Y:   alu_lhs = y_r;
      default: alu_lhs = t1_r;
    endcase
    if (cw.alu_sub) begin
      alu_sum = {alu_lhs[DATA_W-1], alu_lhs} - {t2_r[DATA_W-1], t2_r};
    end else begin
      alu_sum = {alu_lhs[DATA_W-1], alu_lhs} + {t2_r[DATA_W-1], t2_r};
    end
    ares = sat_clip({{(PROD_W - DATA_W){alu_sum[DATA_W]}}, alu_sum});
  end

  // Elapsed time saturates at the top of its unsigned range.
  always_comb begin
    tsum  = {1'b0, time_r} + {1'b0, h_r};
    tclip = tsum[TIME_W];
    tnext = tclip ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
  end

  // Configuration writes; indexes past the list are ignored.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    h_nxt = h_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PREY_GROWTH:    a_nxt = $signed(cfg_data);
        CFG_PREDATION_RATE: b_nxt = $signed(cfg_data);
        CFG_PREDATOR_DEATH: c_nxt = $signed(cfg_data);
        CFG_PREDATOR_GAIN:  d_nxt = $signed(cfg_data);
        CFG_STEP_SIZE:      h_nxt = cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: step counter with a branch to the load routine.
  always_comb begin
    state_nxt   = state_r;
    upc_nxt     = upc_r;
    cmd_nxt     = cmd_r;
    ld_prey_nxt = ld_prey_r;
    ld_pred_nxt = ld_pred_r;
    if (in_acc) begin
      state_nxt   = ST_RUN;
      upc_nxt     = '0;
      cmd_nxt     = in_cmd;
      ld_prey_nxt = in_start_prey;
      ld_pred_nxt = in_start_predator;
    end else if (go) begin
      case (cw.seq)
        SEQ_NEXT: upc_nxt = upc_r + UPC_W'(1);
        SEQ_BR_LOAD: begin
          if (cmd_r == CMD_LOAD) begin
            upc_nxt = LOAD_ADDR;
          end else begin
            upc_nxt = upc_r + UPC_W'(1);
          end
        end
        SEQ_END: state_nxt = ST_IDLE;
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // Datapath register writes, all gated by the current control word; a taken result clears out_valid.
  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    time_nxt      = time_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    out_time_nxt  = out_time_r;
    out_prey_nxt  = out_prey_r;
    out_pred_nxt  = out_pred_r;
    out_sat_nxt   = out_sat_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (go) begin
      if (cw.sat_clr) begin
        sat_nxt = 1'b0;
      end
      if (cw.wb_en) begin
        if (cw.wb_dst == WB_T1) begin
          t1_nxt = mres.value;
        end else begin
          t2_nxt = mres.value;
        end
        sat_nxt = sat_nxt | mres.clipped;
      end
      if (cw.alu_en) begin
        case (cw.alu_reg)
          ALU_T1:  t1_nxt = ares.value;
          ALU_X:   x_nxt  = ares.value;
          ALU_Y:   y_nxt  = ares.value;
          default: t1_nxt = ares.value;
        endcase
        sat_nxt = sat_nxt | ares.clipped;
      end
      if (cw.load_en) begin
        x_nxt    = ld_prey_r;
        y_nxt    = ld_pred_r;
        time_nxt = '0;
      end
      if (cw.fin) begin
        // The new predator value is taken straight from the adder.
        time_nxt      = tnext;
        sat_nxt       = sat_nxt | tclip;
        out_valid_nxt = 1'b1;
        out_time_nxt  = tnext;
        out_prey_nxt  = x_r;
        out_pred_nxt  = ares.value;
        out_sat_nxt   = sat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= RST_PREY_GROWTH;
      b_r         <= RST_PREDATION_RATE;
      c_r         <= RST_PREDATOR_DEATH;
      d_r         <= RST_PREDATOR_GAIN;
      h_r         <= RST_STEP_SIZE;
      state_r     <= ST_IDLE;
      upc_r       <= '0;
      x_r         <= RST_PREY;
      y_r         <= RST_PREDATOR;
      time_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      c_r         <= c_nxt;
      d_r         <= d_nxt;
      h_r         <= h_nxt;
      state_r     <= state_nxt;
      upc_r       <= upc_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      time_r      <= time_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ld_prey_r  <= ld_prey_nxt;
    ld_pred_r  <= ld_pred_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    out_time_r <= out_time_nxt;
    out_prey_r <= out_prey_nxt;
    out_pred_r <= out_pred_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_time_now     = out_time_r;
  assign out_prey_now     = out_prey_r;
  assign out_predator_now = out_pred_r;
  assign out_saturated    = out_sat_r;

  // The step counter never leaves the microprogram while running.
  a_upc_in_prog: assert property (@(posedge clk) disable iff (!rst_n)
    run |-> (upc_r < UPC_W'(PROG_LEN)))
    else $error("step counter outside the microprogram");

  // Only step items produce results.
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd_r == CMD_STEP))
    else $error("result produced by a load item");

  // A held final step must not touch the sequencer or the predator state.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> ($stable(upc_r) && $stable(y_r) && $stable(time_r)))
    else $error("state changed while the result was held");

  // Elapsed time never goes backward across a step.
  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (go && cw.fin) |=> (time_r >= $past(time_r)))
    else $error("elapsed time decreased");

endmodule

/* tb/tb_predator_prey_euler_step.sv */
// Self-checking testbench for predator_prey_euler_step, the fixed-point
// Lotka-Volterra Euler stepper. It predicts every step result in a small scoreboard class.
// Depends on ppe_pkg for the port widths, command codes and register indexes.
module tb_predator_prey_euler_step import ppe_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One expected step result, laid out like the result channel.
  typedef struct {
    logic        [TIME_W-1:0] time_now;
    logic signed [DATA_W-1:0] prey;
    logic signed [DATA_W-1:0] predator;
    logic                     saturated;
  } step_result_t;

  // Scoreboard: it keeps its own copy of the coefficients and populations,
  // advances them for every accepted step item and compares the block's results
  // in order against what it worked out.
  class lv_scoreboard;
    localparam longint S32_HI  = (longint'(1) <<< (DATA_W - 1)) - 1;
    localparam longint S32_LO  = -(longint'(1) <<< (DATA_W - 1));
    localparam longint TIME_HI = (longint'(1) <<< TIME_W) - 1;
    localparam longint ONE     = longint'(1) <<< FRAC_BITS;

    longint coef_a, coef_b, coef_c, coef_d, coef_h;
    longint prey, predator, elapsed;
    bit     clipped;

    step_result_t pending_steps[$];
    int mismatches, steps_checked, saturated_steps, loads_seen, reg_writes;

    function new();
      coef_a   = 10 * ONE;
      coef_b   = 3 * (ONE / 4);
      coef_c   = ONE;
      coef_d   = (ONE + 5) / 10;
      coef_h   = (ONE + 100) / 200;
      prey     = 100 * ONE;
      predator = 5 * ONE;
      elapsed  = 0;
    endfunction

    function longint clamp(longint v);
      if (v > S32_HI) begin
        clipped = 1'b1;
        return S32_HI;
      end
      if (v < S32_LO) begin
        clipped = 1'b1;
        return S32_LO;
      end
      return v;
    endfunction

    // Rounds to nearest with ties upward, then floors away the fraction bits.
    function longint qmul(longint p, longint q);
      return clamp((p * q + (ONE >>> 1)) >>> FRAC_BITS);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_PREY_GROWTH:    coef_a = longint'(signed'(data));
        CFG_PREDATION_RATE: coef_b = longint'(signed'(data));
        CFG_PREDATOR_DEATH: coef_c = longint'(signed'(data));
        CFG_PREDATOR_GAIN:  coef_d = longint'(signed'(data));
        CFG_STEP_SIZE:      coef_h = longint'(data[TIME_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_item(logic cmd, logic signed [DATA_W-1:0] start_x,
                            logic signed [DATA_W-1:0] start_y);
      longint dx, xn, dy, yn, t;
      step_result_t r;
      if (cmd == CMD_LOAD) begin
        prey     = start_x;
        predator = start_y;
        elapsed  = 0;
        loads_seen++;
        return;
      end
      clipped = 1'b0;
      dx = clamp(qmul(coef_a, prey) - qmul(coef_b, qmul(prey, predator)));
      xn = clamp(prey + qmul(coef_h, dx));
      // The predator update already sees the new prey value.
      dy = clamp(qmul(coef_d, qmul(xn, predator)) - qmul(coef_c, predator));
      yn = clamp(predator + qmul(coef_h, dy));
      t  = elapsed + coef_h;
      if (t > TIME_HI) begin
        t       = TIME_HI;
        clipped = 1'b1;
      end
      prey        = xn;
      predator    = yn;
      elapsed     = t;
      r.time_now  = t[TIME_W-1:0];
      r.prey      = xn[DATA_W-1:0];
      r.predator  = yn[DATA_W-1:0];
      r.saturated = clipped;
      pending_steps.push_back(r);
    endfunction

    function void check_result(logic [TIME_W-1:0] t, logic signed [DATA_W-1:0] x,
                               logic signed [DATA_W-1:0] y, logic sat);
      step_result_t want;
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: t=%h prey=%h predator=%h sat=%b", t, x, y, sat);
        return;
      end
      want = pending_steps.pop_front();
      steps_checked++;
      if (want.saturated) saturated_steps++;
      if (want.time_now !== t || want.prey !== x || want.predator !== y ||
          want.saturated !== sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Step %0d wrong: expected t=%h prey=%h predator=%h sat=%b, ",
                    "got t=%h prey=%h predator=%h sat=%b"},
                   steps_checked, want.time_now, want.prey, want.predator, want.saturated,
                   t, x, y, sat);
      end
    endfunction

    function int pending();
      return pending_steps.size();
    endfunction
  endclass

  localparam int          RESET_CYCLES = 8;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CHUNK_ITEMS  = 63;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int          Q_ONE        = 1 << FRAC_BITS;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_cmd;
  logic signed [DATA_W-1:0] in_start_prey;
  logic signed [DATA_W-1:0] in_start_predator;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic        [TIME_W-1:0] out_time_now;
  logic signed [DATA_W-1:0] out_prey_now;
  logic signed [DATA_W-1:0] out_predator_now;
  logic                     out_saturated;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic     [CFG_IDX_W-1:0] cfg_index;
  logic        [DATA_W-1:0] cfg_data;

  lv_scoreboard sb;
  int           tx_idle_pct;
  int           rx_idle_pct;
  bit           hold_request = 1'b0;
  bit           hold_taken = 1'b0;
  int           hold_left = 0;
  int unsigned  cycle_count;

  predator_prey_euler_step u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_start_prey     (in_start_prey),
    .in_start_predator (in_start_predator),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_time_now      (out_time_now),
    .out_prey_now      (out_prey_now),
    .out_predator_now  (out_predator_now),
    .out_saturated     (out_saturated),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side. Every result is checked at the edge where it is taken. The
  // ready line then idles at the current rate, except during a long hold-off
  // that the stimulus asks for; that stretch is counted here, so the output
  // register fills and the block has to stall its input.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_time_now, out_prey_now, out_predator_now, out_saturated);
    if (hold_request && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // A hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offers one item, after a random number of idle cycles, and returns at the
  // edge where it was accepted. Valid stays high so that the next item can
  // follow without a bubble; whoever stops sending lowers it.
  task automatic send_item(input logic cmd, input logic signed [DATA_W-1:0] sx,
                           input logic signed [DATA_W-1:0] sy);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_start_prey     <= sx;
    in_start_predator <= sy;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, sx, sy);
  endtask

  // Stops sending and waits until every result is back. A load item yields no
  // result, so some extra cycles cover one that may still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Raises the write channel with one register write and returns at the edge
  // where it was taken. The caller lowers cfg_valid after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Reprograms all five coefficients once the block is idle. Optionally it
  // also writes the unused indexes, which the block must ignore.
  task automatic set_coeffs(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                            input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] d,
                            input logic [DATA_W-1:0] h, input bit poke_unused = 1'b0);
    drain();
    write_reg(CFG_PREY_GROWTH, a);
    write_reg(CFG_PREDATION_RATE, b);
    write_reg(CFG_PREDATOR_DEATH, c);
    write_reg(CFG_PREDATOR_GAIN, d);
    write_reg(CFG_STEP_SIZE, h);
    if (poke_unused) begin
      for (int i = int'(CFG_STEP_SIZE) + 1; i < (1 << CFG_IDX_W); i++)
        write_reg(i[CFG_IDX_W-1:0], $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb                = new();
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_cmd            = CMD_STEP;
    in_start_prey     = '0;
    in_start_predator = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    // First idling pattern: a light sender and a heavily stalling receiver.
    tx_idle_pct = 24;
    rx_idle_pct = 76;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset coefficients. The first steps start from
    // the reset populations; then the loads place the state at the extremes
    // of the number range, at zero and at one negative LSB.
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, S_MAX, S_MIN);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_LOAD, S_MAX, S_MAX);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_LOAD, S_MIN, S_MIN);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_LOAD, '0, '0);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_LOAD, -1, -1);
    send_item(CMD_STEP, '0, '0);
    // Two loads back to back: only the second must count.
    send_item(CMD_LOAD, S_MIN, S_MAX);
    send_item(CMD_LOAD, 100 * Q_ONE, 5 * Q_ONE);
    send_item(CMD_STEP, '0, '0);

    // Extreme coefficients and the largest step, so time saturates on the
    // second step after a load. Bit 31 of the step size write is dropped.
    set_coeffs(S_MAX, S_MIN, S_MIN, S_MAX, '1, 1'b1);
    send_item(CMD_LOAD, Q_ONE, Q_ONE);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_LOAD, S_MAX, S_MIN);
    send_item(CMD_STEP, '0, '0);

    // The opposite extremes and a zero step: time stands still.
    set_coeffs(S_MIN, S_MAX, S_MAX, S_MIN, '0);
    send_item(CMD_LOAD, Q_ONE, -Q_ONE);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, '0, '0);

    // Random part: three idling patterns, each with two coefficient sets.
    // Most sets are plausible ecological values so the populations evolve
    // over many steps; one set is fully random and mostly saturates.
    for (int mode = 0; mode < 3; mode++) begin
      if (mode == 1) begin
        tx_idle_pct = 76;
        rx_idle_pct = 24;
      end else if (mode == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int part = 0; part < 2; part++) begin
        if (mode == 1 && part == 1)
          set_coeffs($urandom, $urandom, $urandom, $urandom, $urandom);
        else
          set_coeffs($urandom_range(20 * Q_ONE), $urandom_range(2 * Q_ONE),
                     $urandom_range(4 * Q_ONE), $urandom_range(Q_ONE),
                     $urandom_range(Q_ONE / 20));
        send_item(CMD_LOAD, $urandom_range(200 * Q_ONE), $urandom_range(50 * Q_ONE));
        for (int k = 0; k < CHUNK_ITEMS; k++) begin
          // Once, the receiver stops for a long stretch while items keep coming.
          if (mode == 0 && part == 0 && k == 30) hold_request = 1'b1;
          if ($urandom_range(99) < 12) begin
            if ($urandom_range(3) == 0)
              send_item(CMD_LOAD, $urandom, $urandom);
            else
              send_item(CMD_LOAD, $urandom_range(200 * Q_ONE),
                        $urandom_range(50 * Q_ONE));
          end else begin
            // The start fields of a step item are ignored, so they carry noise.
            send_item(CMD_STEP, $urandom, $urandom);
          end
        end
      end
    end

    drain();
    $display("Run covered %0d step results (%0d clipped), %0d loads, %0d register writes.",
             sb.steps_checked, sb.saturated_steps, sb.loads_seen, sb.reg_writes);
    $display("Idling went from a stalling receiver to a slow sender to none, with one long stall.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
